// ----- hdl/sclt_pkg.sv -----
// Package for the sign-constrained logistic trainer.
// Holds payload and configuration types, controller codes and the sigmoid table.
// Used by every module of the block; depends on nothing.
`default_nettype none
package sclt_pkg;

  localparam int MAX_SAMPLES_DEF   = 256;
  localparam int FEATURE_COUNT_DEF = 10;
  localparam int IN_FEATURES       = 10;
  localparam int FEAT_W            = 16;
  localparam int W_W               = 32;
  localparam int ACC_W             = 48;
  localparam int SUM_W             = 56;
  localparam int D_W               = 18;
  localparam int G_W               = 34;
  localparam int IDX_W             = 4;
  localparam int STEP_W            = 6;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 20;
  localparam int SIG_LIMIT         = 20;
  localparam int PROB_ONE          = 65536;

  localparam logic [CFG_IDX_W-1:0] CFG_RESTRICTED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGN_RULES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_RATE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EPOCH_LIM  = 3'd4;

  localparam logic [19:0] SIGN_RULES_RST = 20'd2304;
  localparam logic [15:0] LEARN_RATE_RST = 16'd39322;
  localparam logic [15:0] DECAY_RATE_RST = 16'd5033;
  localparam logic [11:0] EPOCH_LIM_RST  = 12'd600;

  typedef struct packed {
    logic signed [15:0] feature_0;
    logic signed [15:0] feature_1;
    logic signed [15:0] feature_2;
    logic signed [15:0] feature_3;
    logic signed [15:0] feature_4;
    logic signed [15:0] feature_5;
    logic signed [15:0] feature_6;
    logic signed [15:0] feature_7;
    logic signed [15:0] feature_8;
    logic signed [15:0] feature_9;
    logic               class_label;
    logic               final_sample;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         coefficient_index;
    logic signed [15:0] coefficient_value;
    logic               final_coefficient;
  } out_item_t;

  typedef struct packed {
    logic        restricted_mode;
    logic [19:0] sign_rules;
    logic [15:0] learning_rate;
    logic [15:0] decay_rate;
    logic [11:0] epoch_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_EPOCH, S_READ, S_DOT, S_Z, S_SIG, S_D,
    S_ACC, S_DIVS, S_DIV, S_DEC, S_G, S_LR, S_WR, S_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_CLR_W, OP_CLR_ACC, OP_READ, OP_DOT, OP_Z, OP_SIG,
    OP_D, OP_ACC, OP_DIVS, OP_DIV, OP_DEC, OP_G, OP_LR, OP_WR, OP_OUT, OP_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [IDX_W-1:0] idx;
    logic             mul;
    logic             add;
    logic             bias;
  } cmd_t;

  function automatic logic [16:0] sig_lut(input logic [4:0] idx);
    logic [16:0] v;
    case (idx)
      5'd0:    v = 17'd32768;
      5'd1:    v = 17'd47911;
      5'd2:    v = 17'd57724;
      5'd3:    v = 17'd62428;
      5'd4:    v = 17'd64357;
      5'd5:    v = 17'd65097;
      5'd6:    v = 17'd65374;
      5'd7:    v = 17'd65476;
      5'd8:    v = 17'd65514;
      5'd9:    v = 17'd65528;
      5'd10:   v = 17'd65533;
      5'd11:   v = 17'd65535;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/sclt_ctrl.sv -----
// Controller of the sign-constrained logistic trainer.
// Sequences loading, epochs, per-sample steps, weight updates and output.
// Depends on sclt_pkg.
`default_nettype none
module sclt_ctrl
  import sclt_pkg::*;
#(
  parameter int MAX_SAMPLES   = MAX_SAMPLES_DEF,
  parameter int FEATURE_COUNT = FEATURE_COUNT_DEF,
  localparam int CW = $clog2(MAX_SAMPLES + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          final_sample,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire logic [11:0]   epoch_limit,
  input  wire logic [CW-1:0] n_count,
  output cmd_t               cmd,
  output logic [CW-1:0]      rd_addr
);

  localparam logic [IDX_W-1:0] FC_IDX = IDX_W'(FEATURE_COUNT);

  state_t            state_r, state_nxt;
  logic [11:0]       epoch_r, epoch_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      epoch_r <= '0;
      k_r     <= '0;
      i_r     <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      epoch_r <= epoch_nxt;
      k_r     <= k_nxt;
      i_r     <= i_nxt;
      step_r  <= step_nxt;
    end
  end

  assign rd_addr = k_r;

  always_comb begin
    state_nxt = state_r;
    epoch_nxt = epoch_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    step_nxt  = step_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd.op    = OP_NOP;
    cmd.idx   = i_r;
    cmd.mul   = (i_r != FC_IDX);
    cmd.add   = (i_r != '0);
    cmd.bias  = (i_r == FC_IDX);
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_LOAD;
          if (final_sample) begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.op    = OP_CLR_W;
        epoch_nxt = '0;
        i_nxt     = '0;
        if (n_count == '0 || epoch_limit == '0) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_EPOCH;
        end
      end
      S_EPOCH: begin
        cmd.op    = OP_CLR_ACC;
        k_nxt     = '0;
        state_nxt = S_READ;
      end
      S_READ: begin
        cmd.op    = OP_READ;
        i_nxt     = '0;
        state_nxt = S_DOT;
      end
      S_DOT: begin
        cmd.op = OP_DOT;
        if (i_r == FC_IDX) begin
          state_nxt = S_Z;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_Z: begin
        cmd.op    = OP_Z;
        state_nxt = S_SIG;
      end
      S_SIG: begin
        cmd.op    = OP_SIG;
        state_nxt = S_D;
      end
      S_D: begin
        cmd.op    = OP_D;
        i_nxt     = '0;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op = OP_ACC;
        if (i_r == FC_IDX) begin
          i_nxt = '0;
          if (k_r + 1'b1 == n_count) begin
            state_nxt = S_DIVS;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_READ;
          end
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_DIVS: begin
        cmd.op    = OP_DIVS;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op   = OP_DIV;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(ACC_W - 1)) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.op    = OP_DEC;
        state_nxt = S_G;
      end
      S_G: begin
        cmd.op    = OP_G;
        state_nxt = S_LR;
      end
      S_LR: begin
        cmd.op    = OP_LR;
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.op = OP_WR;
        if (i_r == FC_IDX) begin
          i_nxt     = '0;
          epoch_nxt = epoch_r + 1'b1;
          if (epoch_r + 1'b1 == epoch_limit) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_EPOCH;
          end
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_DIVS;
        end
      end
      S_OUT: begin
        cmd.op    = OP_OUT;
        out_valid = 1'b1;
        if (out_ready) begin
          if (i_r == FC_IDX) begin
            cmd.op    = OP_DONE;
            i_nxt     = '0;
            state_nxt = S_IDLE;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/sclt_datapath.sv -----
// Datapath of the sign-constrained logistic trainer.
// Sample memory, weights, accumulators, sigmoid, divider and update arithmetic.
// Depends on sclt_pkg; driven by commands from sclt_ctrl.
`default_nettype none
module sclt_datapath
  import sclt_pkg::*;
#(
  parameter int MAX_SAMPLES   = MAX_SAMPLES_DEF,
  parameter int FEATURE_COUNT = FEATURE_COUNT_DEF,
  localparam int CW = $clog2(MAX_SAMPLES + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cmd_t          cmd,
  input  wire logic [CW-1:0] rd_addr,
  input  wire in_item_t      in_data,
  input  wire cfg_t          cfg,
  output logic [CW-1:0]      n_count,
  output out_item_t          out_data
);

  localparam int AW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int IW    = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
  localparam int ROW_W = FEATURE_COUNT * FEAT_W + 1;

  logic [ROW_W-1:0] mem [MAX_SAMPLES];
  logic [ROW_W-1:0] row_r;
  logic [ROW_W-1:0] row_w;
  logic [FEAT_W-1:0] feat_in [IN_FEATURES];
  logic [CW-1:0] count_r;
  logic do_write;

  logic signed [W_W-1:0]   w_r [FEATURE_COUNT];
  logic signed [W_W-1:0]   bias_r;
  logic signed [ACC_W-1:0] acc_r [FEATURE_COUNT];
  logic signed [ACC_W-1:0] accb_r;
  logic signed [ACC_W-1:0] prod_r;
  logic [IW-1:0]           pidx_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] z_r;
  logic [16:0]             lo_r;
  logic [32:0]             sprod_r;
  logic                    sat_r;
  logic                    neg_r;
  logic signed [D_W-1:0]   d_r;
  logic                    qneg_r;
  logic [ACC_W-1:0]        dvd_r;
  logic [CW-1:0]           rem_r;
  logic signed [48:0]      dprod_r;
  logic signed [G_W-1:0]   g_r;
  logic signed [50:0]      lprod_r;

  logic [IW-1:0]           widx;
  logic signed [FEAT_W-1:0] x_sel;
  logic signed [W_W-1:0]   mul_a;
  logic signed [ACC_W-1:0] mul_p;
  logic [SUM_W-1:0]        a_abs;
  logic [4:0]              tidx;
  logic [16:0]             t_lo;
  logic [16:0]             t_hi;
  logic [17:0]             s_val;
  logic signed [18:0]      p_val;
  logic signed [ACC_W-1:0] div_src;
  logic [CW:0]             rem_sh;
  logic                    rem_ge;
  logic signed [G_W-1:0]   q_val;
  logic signed [50:0]      delta;
  logic signed [51:0]      nw_wide;
  logic signed [W_W-1:0]   nw_sat;
  logic signed [W_W-1:0]   nw;
  logic [1:0]              rule;
  logic signed [W_W-1:0]   out_src;
  logic signed [G_W-1:0]   ov;
  logic signed [G_W-1:0]   oq;
  logic signed [15:0]      oq_sat;

  assign feat_in[0] = in_data.feature_0;
  assign feat_in[1] = in_data.feature_1;
  assign feat_in[2] = in_data.feature_2;
  assign feat_in[3] = in_data.feature_3;
  assign feat_in[4] = in_data.feature_4;
  assign feat_in[5] = in_data.feature_5;
  assign feat_in[6] = in_data.feature_6;
  assign feat_in[7] = in_data.feature_7;
  assign feat_in[8] = in_data.feature_8;
  assign feat_in[9] = in_data.feature_9;

  always_comb begin
    row_w = '0;
    for (int j = 0; j < FEATURE_COUNT; j++) begin
      row_w[j*FEAT_W +: FEAT_W] = feat_in[j];
    end
    row_w[ROW_W-1] = in_data.class_label;
  end

  assign do_write = (cmd.op == OP_LOAD) && (count_r < CW'(MAX_SAMPLES));
  assign n_count  = count_r;

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[count_r[AW-1:0]] <= row_w;
    end
    if (cmd.op == OP_READ) begin
      row_r <= mem[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (do_write) begin
      count_r <= count_r + 1'b1;
    end else if (cmd.op == OP_DONE) begin
      count_r <= '0;
    end
  end

  assign widx  = cmd.idx[IW-1:0];
  assign x_sel = row_r[widx*FEAT_W +: FEAT_W];
  assign mul_a = (cmd.op == OP_DOT) ? w_r[widx] : W_W'(d_r);
  assign mul_p = mul_a * x_sel;

  always_comb begin
    a_abs = z_r[SUM_W-1] ? SUM_W'(-z_r) : SUM_W'(z_r);
    tidx  = a_abs[20:16];
    t_lo  = sig_lut(tidx);
    t_hi  = sig_lut(tidx + 5'd1);
    s_val = sat_r ? 18'(PROB_ONE) : (18'(lo_r) + 18'(sprod_r[32:16]));
    p_val = neg_r ? (19'(PROB_ONE) - $signed({1'b0, s_val})) : $signed({1'b0, s_val});
    div_src = cmd.bias ? accb_r : acc_r[widx];
    rem_sh  = {rem_r, dvd_r[ACC_W-1]};
    rem_ge  = (rem_sh >= {1'b0, count_r});
    q_val   = qneg_r ? -$signed({1'b0, dvd_r[G_W-2:0]}) : $signed({1'b0, dvd_r[G_W-2:0]});
    delta   = cmd.bias ? (lprod_r >>> 16) : (lprod_r >>> 24);
    nw_wide = (cmd.bias ? 52'(bias_r) : 52'(w_r[widx])) - 52'(delta);
    if (nw_wide > 52'sd2147483647) begin
      nw_sat = 32'sh7fffffff;
    end else if (nw_wide < -52'sd2147483648) begin
      nw_sat = 32'sh80000000;
    end else begin
      nw_sat = W_W'(nw_wide);
    end
    rule = cfg.sign_rules[2*widx +: 2];
    nw   = nw_sat;
    if (cfg.restricted_mode) begin
      if (rule == 2'd2 || (rule == 2'd0 && nw_sat < 0) || (rule == 2'd1 && nw_sat > 0)) begin
        nw = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CLR_W: begin
        for (int j = 0; j < FEATURE_COUNT; j++) begin
          w_r[j] <= '0;
        end
        bias_r <= '0;
      end
      OP_CLR_ACC: begin
        for (int j = 0; j < FEATURE_COUNT; j++) begin
          acc_r[j] <= '0;
        end
        accb_r <= '0;
      end
      OP_READ: begin
        sum_r <= '0;
      end
      OP_DOT: begin
        if (cmd.mul) begin
          prod_r <= mul_p;
          pidx_r <= widx;
        end
        if (cmd.add) begin
          sum_r <= sum_r + SUM_W'(prod_r);
        end
      end
      OP_Z: begin
        z_r <= SUM_W'(bias_r) + (sum_r >>> 8);
      end
      OP_SIG: begin
        sat_r   <= (a_abs >= SUM_W'(SIG_LIMIT * PROB_ONE));
        neg_r   <= z_r[SUM_W-1];
        lo_r    <= t_lo;
        sprod_r <= (t_hi - t_lo) * a_abs[15:0];
      end
      OP_D: begin
        d_r <= D_W'(p_val - (row_r[ROW_W-1] ? 19'sd65536 : 19'sd0));
      end
      OP_ACC: begin
        if (cmd.mul) begin
          prod_r <= mul_p;
          pidx_r <= widx;
        end
        if (cmd.add) begin
          acc_r[pidx_r] <= acc_r[pidx_r] + prod_r;
        end else begin
          accb_r <= accb_r + ACC_W'(d_r);
        end
      end
      OP_DIVS: begin
        qneg_r <= div_src[ACC_W-1];
        dvd_r  <= div_src[ACC_W-1] ? ACC_W'(-div_src) : ACC_W'(div_src);
        rem_r  <= '0;
      end
      OP_DIV: begin
        rem_r <= rem_ge ? CW'(rem_sh - {1'b0, count_r}) : rem_sh[CW-1:0];
        dvd_r <= {dvd_r[ACC_W-2:0], rem_ge};
      end
      OP_DEC: begin
        dprod_r <= $signed({1'b0, cfg.decay_rate}) * w_r[widx];
      end
      OP_G: begin
        g_r <= cmd.bias ? q_val : (q_val + G_W'(dprod_r >>> 16));
      end
      OP_LR: begin
        lprod_r <= $signed({1'b0, cfg.learning_rate}) * g_r;
      end
      OP_WR: begin
        if (cmd.bias) begin
          bias_r <= nw_sat;
        end else begin
          w_r[widx] <= nw;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_src = cmd.bias ? bias_r : w_r[widx];
    ov      = G_W'(out_src);
    if (ov >= 0) begin
      oq = (ov + 34'sd128) >>> 8;
    end else begin
      oq = -((-ov + 34'sd128) >>> 8);
    end
    if (oq > 34'sd32767) begin
      oq_sat = 16'sh7fff;
    end else if (oq < -34'sd32768) begin
      oq_sat = 16'sh8000;
    end else begin
      oq_sat = 16'(oq);
    end
    out_data.coefficient_index = cmd.idx;
    out_data.coefficient_value = oq_sat;
    out_data.final_coefficient = cmd.bias;
  end

endmodule
`default_nettype wire

// ----- hdl/sign_constrained_logistic_trainer_top.sv -----
// Top level: samples load one per cycle while idle. The final sample starts training
// for E epochs over n samples and F features, with a sequential dot product and
// accumulate and a bit-serial divider. The F+1 coefficients then leave at up to one
// per cycle while out_ready is high. Synchronous active-low reset clears control
// state and restores register defaults; sample memory is not cleared.
// Depends on sclt_pkg, sclt_ctrl and sclt_datapath.
`default_nettype none
module sign_constrained_logistic_trainer_top
  import sclt_pkg::*;
#(
  parameter int MAX_SAMPLES   = MAX_SAMPLES_DEF,
  parameter int FEATURE_COUNT = FEATURE_COUNT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);

  cfg_t          cfg_r, cfg_nxt;
  cmd_t          cmd;
  logic [CW-1:0] rd_addr;
  logic [CW-1:0] n_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.restricted_mode <= 1'b0;
      cfg_r.sign_rules      <= SIGN_RULES_RST;
      cfg_r.learning_rate   <= LEARN_RATE_RST;
      cfg_r.decay_rate      <= DECAY_RATE_RST;
      cfg_r.epoch_limit     <= EPOCH_LIM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_RESTRICTED: cfg_nxt.restricted_mode = cfg_wdata[0];
        CFG_SIGN_RULES: cfg_nxt.sign_rules      = cfg_wdata;
        CFG_LEARN_RATE: cfg_nxt.learning_rate   = cfg_wdata[15:0];
        CFG_DECAY_RATE: cfg_nxt.decay_rate      = cfg_wdata[15:0];
        CFG_EPOCH_LIM:  cfg_nxt.epoch_limit     = cfg_wdata[11:0];
        default: begin
        end
      endcase
    end
  end

  sclt_ctrl #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .FEATURE_COUNT(FEATURE_COUNT)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .final_sample(in_data.final_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .epoch_limit(cfg_r.epoch_limit),
    .n_count(n_count),
    .cmd(cmd),
    .rd_addr(rd_addr)
  );

  sclt_datapath #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .FEATURE_COUNT(FEATURE_COUNT)
  ) u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .rd_addr(rd_addr),
    .in_data(in_data),
    .cfg(cfg_r),
    .n_count(n_count),
    .out_data(out_data)
  );

endmodule
`default_nettype wire

// ----- dv/sign_constrained_logistic_trainer_top_tb.sv -----
// Testbench for the sign-constrained logistic trainer: directed and random sample batches.
// Results are checked by a scoreboard class that retrains each batch in plain arithmetic.
// Depends on sclt_pkg and sign_constrained_logistic_trainer_top.
`timescale 1ns / 100ps

module sign_constrained_logistic_trainer_top_tb;
  import sclt_pkg::*;

  class coeff_scoreboard;
    bit          restricted;
    int          sign_rules;
    int          learn_rate;
    int          decay_rate;
    int          epoch_lim;
    shortint     feats[256][10];
    bit          labels[256];
    int          n_loaded;
    out_item_t   expected_q[$];
    int          errors;
    int          sig_tab[21] = '{32768, 47911, 57724, 62428, 64357, 65097, 65374, 65476,
                                 65514, 65528, 65533, 65535, 65536, 65536, 65536, 65536,
                                 65536, 65536, 65536, 65536, 65536};

    function new();
      restricted = 0;
      sign_rules = 2304;
      learn_rate = 39322;
      decay_rate = 5033;
      epoch_lim  = 600;
      n_loaded   = 0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, int val);
      case (idx)
        CFG_RESTRICTED: restricted = val[0];
        CFG_SIGN_RULES: sign_rules = val & 20'hFFFFF;
        CFG_LEARN_RATE: learn_rate = val & 16'hFFFF;
        CFG_DECAY_RATE: decay_rate = val & 16'hFFFF;
        CFG_EPOCH_LIM:  epoch_lim  = val & 12'hFFF;
        default: ;
      endcase
    endfunction

    function longint sigmoid(longint z);
      longint a, s, fr;
      int idx;
      a = (z < 0) ? -z : z;
      if (a >= (longint'(20) << 16)) begin
        s = 65536;
      end else begin
        idx = int'(a >> 16);
        fr = a & 65535;
        s = sig_tab[idx] + (((longint'(sig_tab[idx + 1] - sig_tab[idx])) * fr) >>> 16);
      end
      return (z < 0) ? 65536 - s : s;
    endfunction

    function int sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
    endfunction

    function logic [15:0] round_q8(int v);
      longint w, q;
      w = v;
      if (w >= 0) q = (w + 128) >>> 8;
      else q = -((-w + 128) >>> 8);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
    endfunction

    function void train_and_predict();
      int w[10];
      int b;
      longint acc[11];
      longint sum, z, d, g, gb;
      int nw, rule;
      out_item_t r;
      b = 0;
      foreach (w[i]) w[i] = 0;
      for (int e = 0; e < epoch_lim; e++) begin
        foreach (acc[i]) acc[i] = 0;
        for (int k = 0; k < n_loaded; k++) begin
          sum = 0;
          for (int i = 0; i < 10; i++) sum += longint'(w[i]) * feats[k][i];
          z = longint'(b) + (sum >>> 8);
          d = sigmoid(z) - (labels[k] ? 65536 : 0);
          for (int i = 0; i < 10; i++) acc[i] += d * feats[k][i];
          acc[10] += d;
        end
        for (int i = 0; i < 10; i++) begin
          g = acc[i] / longint'(n_loaded) + ((longint'(decay_rate) * w[i]) >>> 16);
          nw = sat32(longint'(w[i]) - ((longint'(learn_rate) * g) >>> 24));
          if (restricted) begin
            rule = (sign_rules >> (2 * i)) & 3;
            if (rule == 2 || (rule == 0 && nw < 0) || (rule == 1 && nw > 0)) nw = 0;
          end
          w[i] = nw;
        end
        gb = acc[10] / longint'(n_loaded);
        b = sat32(longint'(b) - ((longint'(learn_rate) * gb) >>> 16));
      end
      for (int i = 0; i <= 10; i++) begin
        r.coefficient_index = 4'(i);
        r.coefficient_value = round_q8((i < 10) ? w[i] : b);
        r.final_coefficient = (i == 10);
        expected_q.push_back(r);
      end
    endfunction

    function void note_sample(in_item_t it);
      if (n_loaded < 256) begin
        feats[n_loaded] = '{it.feature_0, it.feature_1, it.feature_2, it.feature_3,
                            it.feature_4, it.feature_5, it.feature_6, it.feature_7,
                            it.feature_8, it.feature_9};
        labels[n_loaded] = it.class_label;
        n_loaded++;
      end
      if (it.final_sample) begin
        train_and_predict();
        n_loaded = 0;
      end
    endfunction

    function void check_coeff(out_item_t got);
      out_item_t exp_c;
      if (expected_q.size() == 0) begin
        $error("unexpected coefficient transfer %p", got);
        errors++;
        return;
      end
      exp_c = expected_q.pop_front();
      if (got.coefficient_index !== exp_c.coefficient_index) begin
        $error("coefficient_index: expected %0d, got %0d",
               exp_c.coefficient_index, got.coefficient_index);
        errors++;
      end
      if (got.coefficient_value !== exp_c.coefficient_value) begin
        $error("coefficient_value: expected %0d, got %0d",
               exp_c.coefficient_value, got.coefficient_value);
        errors++;
      end
      if (got.final_coefficient !== exp_c.final_coefficient) begin
        $error("final_coefficient: expected %0d, got %0d",
               exp_c.final_coefficient, got.final_coefficient);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  coeff_scoreboard sb = new();
  bit  quiet;
  int  hold_len;

  sign_constrained_logistic_trainer_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    #60ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_ready = 1'b0;
        hold_len--;
      end else begin
        out_ready = quiet || ($urandom_range(99) >= 32);
      end
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_coeff(out_data);
    end
  end

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = CFG_DATA_W'(val);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    while (sb.expected_q.size() > 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic send_sample(in_item_t it);
    while (!quiet && $urandom_range(99) < 32) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(it);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic logic [15:0] pick_feature(int style);
    case (style)
      0: return 16'($signed($urandom_range(1023)) - 512);
      1: return 16'($urandom);
      default: begin
        case ($urandom_range(2))
          0: return 16'h7FFF;
          1: return 16'h8000;
          default: return 16'h0000;
        endcase
      end
    endcase
  endfunction

  task automatic send_batch(int n, int style);
    in_item_t it;
    for (int k = 0; k < n; k++) begin
      it = {pick_feature(style), pick_feature(style), pick_feature(style),
            pick_feature(style), pick_feature(style), pick_feature(style),
            pick_feature(style), pick_feature(style), pick_feature(style),
            pick_feature(style), 1'($urandom), 1'(k == n - 1)};
      send_sample(it);
    end
  endtask

  initial begin
    in_item_t it;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_RESTRICTED;
    cfg_wdata = '0;
    quiet = 1'b0;
    hold_len = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Register defaults: a short batch trained for the reset epoch count.
    send_batch(2, 0);
    drain();

    // Corner features with both labels, projection on, every sign rule present.
    write_cfg(CFG_EPOCH_LIM, 3);
    write_cfg(CFG_RESTRICTED, 1);
    write_cfg(CFG_SIGN_RULES, 20'b11_10_01_00_11_10_01_00_01_00);
    write_cfg(CFG_LEARN_RATE, 16'hFFFF);
    write_cfg(CFG_DECAY_RATE, 16'hFFFF);
    it = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001,
          16'h7FFF, 16'h8000, 16'h0100, 1'b1, 1'b0};
    send_sample(it);
    it = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF,
          16'h8000, 16'h7FFF, 16'hFF00, 1'b0, 1'b0};
    send_sample(it);
    send_batch(3, 2);
    drain();

    // Zero learning rate and decay, projection off.
    write_cfg(CFG_RESTRICTED, 0);
    write_cfg(CFG_LEARN_RATE, 0);
    write_cfg(CFG_DECAY_RATE, 0);
    write_cfg(CFG_EPOCH_LIM, 1);
    send_batch(4, 1);
    drain();

    // Zero epochs: every coefficient comes out zero.
    write_cfg(CFG_EPOCH_LIM, 0);
    write_cfg(CFG_LEARN_RATE, 39322);
    send_batch(3, 0);
    drain();

    // Storage full: extra samples, the final one among them, are not stored; the final one still starts training.
    write_cfg(CFG_EPOCH_LIM, 2);
    send_batch(260, 0);
    drain();

    // The receiver holds off while the sender keeps offering batches.
    hold_len = 3000;
    send_batch(3, 0);
    send_batch(2, 1);
    drain();

    for (int bnum = 0; bnum < 8; bnum++) begin
      quiet = (bnum >= 2 && bnum < 6);
      if ($urandom_range(99) < 35) begin
        drain();
        write_cfg(CFG_RESTRICTED, $urandom_range(1));
        write_cfg(CFG_SIGN_RULES, $urandom_range(20'hFFFFF));
        case ($urandom_range(3))
          0: write_cfg(CFG_LEARN_RATE, $urandom_range(65535));
          1: write_cfg(CFG_LEARN_RATE, 65535);
          default: write_cfg(CFG_LEARN_RATE, $urandom_range(20000, 45000));
        endcase
        write_cfg(CFG_DECAY_RATE, ($urandom_range(3) == 0) ? $urandom_range(65535)
                                                             : $urandom_range(8000));
        write_cfg(CFG_EPOCH_LIM, ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8));
      end
      send_batch(($urandom_range(9) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 4),
                 ($urandom_range(3) == 0) ? 1 : 0);
      if ($urandom_range(3) == 0) drain();
    end
    quiet = 1'b0;

    drain();
    repeat (50) @(negedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/sclt_pkg.sv
hdl/sclt_ctrl.sv
hdl/sclt_datapath.sv
hdl/sign_constrained_logistic_trainer_top.sv
dv/sign_constrained_logistic_trainer_top_tb.sv
